// ===== rtl/edf_budget_scheduler_top_defines.svh =====
// assertion macros for the edf budget scheduler
`ifndef EDF_BUDGET_SCHEDULER_TOP_DEFINES_SVH
`define EDF_BUDGET_SCHEDULER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define EDFBS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define EDFBS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/edfbs_pkg.sv =====
// shared types, constants and helpers of the edf budget scheduler
package edfbs_pkg;

	localparam int FUNC_W     = 2;
	localparam int ID_W       = 8;
	localparam int PER_W      = 12;
	localparam int BUD_W      = 8;
	localparam int FDL_W      = 16;
	localparam int TIME_W     = 32;
	localparam int HP_W       = 17;
	localparam int LP_W       = 13;
	localparam int MPT_W      = 10;
	localparam int SLC_W      = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	localparam logic [FUNC_W-1:0] FN_ADD  = 2'd0;
	localparam logic [FUNC_W-1:0] FN_TICK = 2'd1;
	localparam logic [FUNC_W-1:0] FN_PICK = 2'd2;
	localparam logic [FUNC_W-1:0] FN_NOP  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_MS_PER_TICK      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_MIN_PERIOD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_MAX_BUDGET = 2'd2;

	localparam logic [MPT_W-1:0] MPT_RST  = 10'd10;
	localparam logic [LP_W-1:0]  SMIN_RST = 13'd5000;
	localparam logic [BUD_W-1:0] SMAX_RST = 8'd200;

	localparam int PERIOD_CNT = 14;
	localparam int BUDGET_CNT = 8;

	localparam logic [PER_W-1:0] PERIOD_SET [0:PERIOD_CNT-1] = '{
		12'd5, 12'd10, 12'd20, 12'd50, 12'd100, 12'd200, 12'd300,
		12'd400, 12'd500, 12'd600, 12'd700, 12'd800, 12'd1000, 12'd4000
	};
	localparam logic [BUD_W-1:0] BUDGET_SET [0:BUDGET_CNT-1] = '{
		8'd1, 8'd2, 8'd5, 8'd10, 8'd20, 8'd50, 8'd100, 8'd200
	};

	typedef enum logic [4:0] {
		S_IDLE,
		S_ADD,
		S_GCD_GO,
		S_GCD_WAIT,
		S_HDIV_GO,
		S_HDIV_WAIT,
		S_HMUL,
		S_ADD_BUD,
		S_INIT,
		S_SIM_CHK,
		S_SIM_SCAN,
		S_SIM_RD,
		S_SIM_UPD,
		S_ACC,
		S_TICK,
		S_TICK_UPD,
		S_PICK_SCAN,
		S_PICK_MUL,
		S_PICK_FIN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [PER_W-1:0] period;
		logic [BUD_W-1:0] budget;
		logic [FDL_W-1:0] first;
	} st_word_t;

	typedef struct packed {
		logic [TIME_W-1:0] deadline;
		logic [TIME_W-1:0] window;
	} dyn_word_t;

	typedef struct packed {
		logic              start;
		logic [HP_W-1:0]   num;
		logic [HP_W-1:0]   den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [HP_W-1:0]   quo;
		logic [HP_W-1:0]   rem;
	} div_rsp_t;

	function automatic logic period_ok(input logic [PER_W-1:0] v, input int n);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < PERIOD_CNT; i++) begin
			if (i < n && PERIOD_SET[i] == v) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

	function automatic logic budget_ok(input logic [BUD_W-1:0] v, input int n);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < BUDGET_CNT; i++) begin
			if (i < n && BUDGET_SET[i] == v) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

endpackage

// ===== rtl/edfbs_if.sv =====
// request and response channel interfaces of the edf budget scheduler
interface edfbs_in_if;
	logic                              valid;
	logic                              ready;
	logic [edfbs_pkg::FUNC_W-1:0]      func;
	logic [edfbs_pkg::ID_W-1:0]        task_id;
	logic [edfbs_pkg::PER_W-1:0]       task_period;
	logic [edfbs_pkg::BUD_W-1:0]       task_budget;
	logic [edfbs_pkg::FDL_W-1:0]       first_deadline;

	modport source(output valid, func, task_id, task_period, task_budget, first_deadline,
		input ready);
	modport sink(input valid, func, task_id, task_period, task_budget, first_deadline,
		output ready);
endinterface

interface edfbs_out_if;
	logic                              valid;
	logic                              ready;
	logic                              status;
	logic                              has_task;
	logic [edfbs_pkg::ID_W-1:0]        chosen_id;
	logic                              reschedule;

	modport source(output valid, status, has_task, chosen_id, reschedule, input ready);
	modport sink(input valid, status, has_task, chosen_id, reschedule, output ready);
endinterface

// ===== rtl/edfbs_ram.sv =====
// generic single write, single registered read ram
module edfbs_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
	input  logic [W-1:0]                   wdata,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
	output logic [W-1:0]                   rdata
);
	logic [W-1:0] mem [0:D-1];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== rtl/edfbs_div.sv =====
// restoring divider, one quotient bit per cycle, shared by gcd and lcm steps
module edfbs_div (
	input  logic                clk,
	input  logic                arst_n,
	input  edfbs_pkg::div_req_t req,
	output edfbs_pkg::div_rsp_t rsp
);
	localparam int N     = edfbs_pkg::HP_W;
	localparam int CNT_W = $clog2(N + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [N-1:0]     rem_q;
	logic [N-1:0]     quo_q;
	logic [N-1:0]     den_q;
	logic [N:0]       shifted;
	logic [N:0]       diff;
	logic             ge;

	assign shifted = {rem_q, quo_q[N-1]};
	assign ge      = shifted >= {1'b0, den_q};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(N - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[N-1:0] : shifted[N-1:0];
			quo_q <= {quo_q[N-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;
endmodule

// ===== rtl/edf_budget_scheduler_top.sv =====
// edf budget scheduler: task table, admission by edf simulation, tick and pick
// tick: S_TICK, S_TICK_UPD if a task runs, then S_DONE; pick: serial scan, S_PICK_MUL, S_PICK_FIN
// add: gcd/lcm through divider passes, then the edf simulation runs one
//   table scan per simulated job, until simulated time reaches the hyperperiod
// one item at a time; the result sits in an output register while the next is taken
// reset clears the table count, time, running task and loads the default bounds
`include "edf_budget_scheduler_top_defines.svh"
module edf_budget_scheduler_top #(
	parameter int MAX_TASKS   = 16,
	parameter int NUM_PERIODS = 14,
	parameter int NUM_BUDGETS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	edfbs_in_if.sink                            req,
	edfbs_out_if.source                         rsp,
	input  logic                                cfg_we,
	input  logic [edfbs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [edfbs_pkg::CFG_DATA_W-1:0]    cfg_data
);
	localparam int AW     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CW     = $clog2(MAX_TASKS + 1);
	localparam int TW     = edfbs_pkg::TIME_W;
	localparam int HW     = edfbs_pkg::HP_W;
	localparam int PW     = edfbs_pkg::PER_W;
	localparam int BW     = edfbs_pkg::BUD_W;
	localparam int LW     = edfbs_pkg::LP_W;
	localparam int MW     = edfbs_pkg::MPT_W;
	localparam int SW     = edfbs_pkg::SLC_W;
	localparam int IW     = edfbs_pkg::ID_W;
	localparam int FW     = edfbs_pkg::FDL_W;
	localparam int ST_W   = $bits(edfbs_pkg::st_word_t);
	localparam int DY_W   = $bits(edfbs_pkg::dyn_word_t);
	localparam logic [CW-1:0] CNT_FULL = CW'(MAX_TASKS);

	edfbs_pkg::state_t st_q, st_d;

	logic [CW-1:0]  cnt_q, cnt_d;
	logic [CW-1:0]  addr_q, addr_d;
	logic [CW-1:0]  lim;
	logic           issue, scan_done;
	logic           pend_s1;
	logic [AW-1:0]  idx_s1;
	logic           found_q, found_d;
	logic [AW-1:0]  best_idx_q, best_idx_d;
	logic [TW-1:0]  best_dl_q, best_dl_d;
	logic [TW-1:0]  best_ws_q, best_ws_d;
	logic [TW-1:0]  t_q, t_d;
	logic [TW-1:0]  now_q, now_d;
	logic [AW-1:0]  run_slot_q, run_slot_d;
	logic           run_valid_q, run_valid_d;
	logic [LW-1:0]  least_q, least_d;
	logic [BW-1:0]  largest_q, largest_d;
	logic [HW-1:0]  hp_q, hp_d;
	logic [MW-1:0]  mpt_q, mpt_d;
	logic [HW-1:0]  ga_q, ga_d, gb_q, gb_d, qt_q, qt_d;
	logic [MW+TW-1:0] prod_q, prod_d;
	logic [HW+PW-1:0] hmul;

	logic [edfbs_pkg::FUNC_W-1:0] func_q, func_d;
	logic [IW-1:0]  id_q, id_d;
	logic [PW-1:0]  per_q, per_d;
	logic [BW-1:0]  bud_q, bud_d;
	logic [FW-1:0]  first_q, first_d;

	logic           r_status_q, r_status_d, r_has_q, r_has_d, r_resched_q, r_resched_d;
	logic [IW-1:0]  r_id_q, r_id_d;
	logic           o_valid_q, o_valid_d, o_status_q, o_status_d, o_has_q, o_has_d;
	logic           o_resched_q, o_resched_d;
	logic [IW-1:0]  o_id_q, o_id_d;

	// scratch and candidate values
	logic [LW-1:0]  lp_n;
	logic [BW-1:0]  lb_n;
	logic [TW:0]    t_bud;
	logic [TW-1:0]  t_max;
	logic [TW-1:0]  per_ext;
	logic [SW-1:0]  slc_new;
	logic [TW-1:0]  cand_dl, cand_ws;

	// ram ports
	logic           st_we, dy_we, sc_we, sl_we;
	logic [AW-1:0]  st_waddr, dy_waddr, sc_waddr, sl_waddr;
	logic [AW-1:0]  st_raddr, dy_raddr, sc_raddr;
	edfbs_pkg::st_word_t  st_wdata, st_rdata;
	edfbs_pkg::dyn_word_t dy_wdata, dy_rdata, sc_wdata, sc_rdata;
	logic [SW-1:0]  sl_wdata, sl_rdata;

	edfbs_pkg::div_req_t div_req;
	edfbs_pkg::div_rsp_t div_rsp;

	edfbs_ram #(.W(ST_W), .D(MAX_TASKS)) u_st_ram (
		.clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
		.raddr(st_raddr), .rdata(st_rdata)
	);
	edfbs_ram #(.W(DY_W), .D(MAX_TASKS)) u_dy_ram (
		.clk(clk), .we(dy_we), .waddr(dy_waddr), .wdata(dy_wdata),
		.raddr(dy_raddr), .rdata(dy_rdata)
	);
	edfbs_ram #(.W(DY_W), .D(MAX_TASKS)) u_sc_ram (
		.clk(clk), .we(sc_we), .waddr(sc_waddr), .wdata(sc_wdata),
		.raddr(sc_raddr), .rdata(sc_rdata)
	);
	edfbs_ram #(.W(SW), .D(MAX_TASKS)) u_sl_ram (
		.clk(clk), .we(sl_we), .waddr(sl_waddr), .wdata(sl_wdata),
		.raddr(run_slot_q), .rdata(sl_rdata)
	);

	edfbs_div u_div (
		.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp)
	);

	assign hmul = qt_q * per_q;

	// serial scan over the table, one read issued per cycle
	assign lim = (st_q == edfbs_pkg::S_PICK_SCAN) ? cnt_q : (cnt_q + CW'(1));
	assign issue = ((st_q == edfbs_pkg::S_INIT) || (st_q == edfbs_pkg::S_SIM_SCAN) ||
		(st_q == edfbs_pkg::S_ACC) || (st_q == edfbs_pkg::S_PICK_SCAN)) && (addr_q < lim);
	assign scan_done = !issue && !pend_s1;

	always_comb begin
		st_d        = st_q;
		cnt_d       = cnt_q;
		addr_d      = issue ? (addr_q + CW'(1)) : addr_q;
		found_d     = found_q;
		best_idx_d  = best_idx_q;
		best_dl_d   = best_dl_q;
		best_ws_d   = best_ws_q;
		t_d         = t_q;
		now_d       = now_q;
		run_slot_d  = run_slot_q;
		run_valid_d = run_valid_q;
		least_d     = least_q;
		largest_d   = largest_q;
		hp_d        = hp_q;
		mpt_d       = mpt_q;
		ga_d        = ga_q;
		gb_d        = gb_q;
		qt_d        = qt_q;
		prod_d      = prod_q;
		func_d      = func_q;
		id_d        = id_q;
		per_d       = per_q;
		bud_d       = bud_q;
		first_d     = first_q;
		r_status_d  = r_status_q;
		r_has_d     = r_has_q;
		r_id_d      = r_id_q;
		r_resched_d = r_resched_q;
		o_valid_d   = o_valid_q && !rsp.ready;
		o_status_d  = o_status_q;
		o_has_d     = o_has_q;
		o_id_d      = o_id_q;
		o_resched_d = o_resched_q;

		st_we    = 1'b0;
		st_waddr = cnt_q[AW-1:0];
		st_wdata = '{id: id_q, period: per_q, budget: bud_q, first: first_q};
		dy_we    = 1'b0;
		dy_waddr = run_slot_q;
		dy_wdata = '0;
		sc_we    = 1'b0;
		sc_waddr = best_idx_q;
		sc_wdata = '0;
		sl_we    = 1'b0;
		sl_waddr = run_slot_q;
		sl_wdata = '0;
		sc_raddr = addr_q[AW-1:0];
		dy_raddr = (st_q == edfbs_pkg::S_PICK_SCAN) ? addr_q[AW-1:0] : run_slot_q;
		div_req  = '0;

		unique case (st_q)
			edfbs_pkg::S_INIT, edfbs_pkg::S_ACC: st_raddr = addr_q[AW-1:0];
			edfbs_pkg::S_TICK:                   st_raddr = run_slot_q;
			default:                             st_raddr = best_idx_q;
		endcase

		lp_n    = (least_q > LW'(per_q)) ? LW'(per_q) : least_q;
		lb_n    = (largest_q < bud_q) ? bud_q : largest_q;
		per_ext = TW'(st_rdata.period);
		t_bud   = {1'b0, t_q} + (TW + 1)'(st_rdata.budget);
		t_max   = (t_q < best_ws_q) ? best_ws_q : t_q;
		cand_dl = (st_q == edfbs_pkg::S_PICK_SCAN) ? dy_rdata.deadline : sc_rdata.deadline;
		cand_ws = (st_q == edfbs_pkg::S_PICK_SCAN) ? dy_rdata.window : sc_rdata.window;
		slc_new = sl_rdata - SW'(1);

		unique case (st_q)
			edfbs_pkg::S_IDLE: begin
				if (req.valid) begin
					func_d      = req.func;
					id_d        = req.task_id;
					per_d       = req.task_period;
					bud_d       = req.task_budget;
					first_d     = req.first_deadline;
					r_status_d  = 1'b0;
					r_has_d     = 1'b0;
					r_id_d      = '0;
					r_resched_d = 1'b0;
					addr_d      = '0;
					found_d     = 1'b0;
					unique case (req.func)
						edfbs_pkg::FN_ADD:  st_d = edfbs_pkg::S_ADD;
						edfbs_pkg::FN_TICK: st_d = edfbs_pkg::S_TICK;
						edfbs_pkg::FN_PICK: st_d = edfbs_pkg::S_PICK_SCAN;
						default:            st_d = edfbs_pkg::S_DONE;
					endcase
				end
			end
			edfbs_pkg::S_ADD: begin
				// sticky bounds move even for a rejected task
				least_d   = lp_n;
				largest_d = lb_n;
				if (LW'(lb_n) > lp_n) begin
					r_status_d = 1'b1;
					st_d       = edfbs_pkg::S_DONE;
				end else if (!edfbs_pkg::period_ok(per_q, NUM_PERIODS)) begin
					r_status_d = 1'b1;
					st_d       = edfbs_pkg::S_DONE;
				end else if (hp_q == '0 || hp_q == HW'(per_q)) begin
					hp_d = HW'(per_q);
					st_d = edfbs_pkg::S_ADD_BUD;
				end else begin
					ga_d = hp_q;
					gb_d = HW'(per_q);
					st_d = edfbs_pkg::S_GCD_GO;
				end
			end
			edfbs_pkg::S_GCD_GO: begin
				div_req.start = 1'b1;
				div_req.num   = ga_q;
				div_req.den   = gb_q;
				st_d          = edfbs_pkg::S_GCD_WAIT;
			end
			edfbs_pkg::S_GCD_WAIT: begin
				if (div_rsp.done) begin
					ga_d = gb_q;
					gb_d = div_rsp.rem;
					st_d = (div_rsp.rem == '0) ? edfbs_pkg::S_HDIV_GO : edfbs_pkg::S_GCD_GO;
				end
			end
			edfbs_pkg::S_HDIV_GO: begin
				div_req.start = 1'b1;
				div_req.num   = hp_q;
				div_req.den   = ga_q;
				st_d          = edfbs_pkg::S_HDIV_WAIT;
			end
			edfbs_pkg::S_HDIV_WAIT: begin
				if (div_rsp.done) begin
					qt_d = div_rsp.quo;
					st_d = edfbs_pkg::S_HMUL;
				end
			end
			edfbs_pkg::S_HMUL: begin
				hp_d = hmul[HW-1:0];
				st_d = edfbs_pkg::S_ADD_BUD;
			end
			edfbs_pkg::S_ADD_BUD: begin
				if (!edfbs_pkg::budget_ok(bud_q, NUM_BUDGETS) || cnt_q == CNT_FULL) begin
					r_status_d = 1'b1;
					st_d       = edfbs_pkg::S_DONE;
				end else begin
					st_we  = 1'b1;
					addr_d = '0;
					st_d   = edfbs_pkg::S_INIT;
				end
			end
			edfbs_pkg::S_INIT: begin
				// scratch copy: deadline from first deadline, window at zero
				if (pend_s1) begin
					sc_we    = 1'b1;
					sc_waddr = idx_s1;
					sc_wdata = '{deadline: TW'(st_rdata.first), window: '0};
				end
				if (scan_done) begin
					t_d  = '0;
					st_d = edfbs_pkg::S_SIM_CHK;
				end
			end
			edfbs_pkg::S_SIM_CHK: begin
				addr_d  = '0;
				found_d = 1'b0;
				st_d    = (t_q >= TW'(hp_q)) ? edfbs_pkg::S_ACC : edfbs_pkg::S_SIM_SCAN;
			end
			edfbs_pkg::S_SIM_SCAN, edfbs_pkg::S_PICK_SCAN: begin
				// strict less keeps the lowest slot on a tie
				if (pend_s1 && (!found_q || cand_dl < best_dl_q)) begin
					found_d    = 1'b1;
					best_idx_d = idx_s1;
					best_dl_d  = cand_dl;
					best_ws_d  = cand_ws;
				end
				if (scan_done) begin
					if (st_q == edfbs_pkg::S_SIM_SCAN) begin
						st_d = edfbs_pkg::S_SIM_RD;
					end else begin
						st_d = found_q ? edfbs_pkg::S_PICK_MUL : edfbs_pkg::S_DONE;
					end
				end
			end
			edfbs_pkg::S_SIM_RD: begin
				st_d = edfbs_pkg::S_SIM_UPD;
			end
			edfbs_pkg::S_SIM_UPD: begin
				if (t_bud > {1'b0, best_dl_q}) begin
					r_status_d = 1'b1;
					st_d       = edfbs_pkg::S_DONE;
				end else begin
					t_d      = t_max + TW'(st_rdata.budget);
					sc_we    = 1'b1;
					sc_waddr = best_idx_q;
					sc_wdata = '{deadline: best_dl_q + per_ext, window: best_ws_q + per_ext};
					st_d     = edfbs_pkg::S_SIM_CHK;
				end
			end
			edfbs_pkg::S_ACC: begin
				if (pend_s1) begin
					dy_we    = 1'b1;
					dy_waddr = idx_s1;
					dy_wdata = '{deadline: TW'(st_rdata.first), window: '0};
				end
				if (scan_done) begin
					cnt_d = cnt_q + CW'(1);
					st_d  = edfbs_pkg::S_DONE;
				end
			end
			edfbs_pkg::S_TICK: begin
				now_d = now_q + TW'(1);
				st_d  = run_valid_q ? edfbs_pkg::S_TICK_UPD : edfbs_pkg::S_DONE;
			end
			edfbs_pkg::S_TICK_UPD: begin
				sl_we    = 1'b1;
				sl_waddr = run_slot_q;
				sl_wdata = slc_new;
				if (sl_rdata[SW-1] || sl_rdata == '0) begin
					// exhausted: saturate at the most negative count
					if (sl_rdata == {1'b1, {(SW - 1){1'b0}}}) begin
						sl_wdata = sl_rdata;
					end
					dy_we       = 1'b1;
					dy_waddr    = run_slot_q;
					dy_wdata    = '{deadline: dy_rdata.deadline + per_ext,
						window: dy_rdata.window + per_ext};
					r_resched_d = 1'b1;
				end
				st_d = edfbs_pkg::S_DONE;
			end
			edfbs_pkg::S_PICK_MUL: begin
				prod_d = mpt_q * now_q;
				st_d   = edfbs_pkg::S_PICK_FIN;
			end
			edfbs_pkg::S_PICK_FIN: begin
				if ((MW + TW)'(best_ws_q) <= prod_q) begin
					run_slot_d  = best_idx_q;
					run_valid_d = 1'b1;
					sl_we       = 1'b1;
					sl_waddr    = best_idx_q;
					sl_wdata    = SW'(st_rdata.budget);
					r_has_d     = 1'b1;
					r_id_d      = st_rdata.id;
				end
				st_d = edfbs_pkg::S_DONE;
			end
			edfbs_pkg::S_DONE: begin
				if (!o_valid_q || rsp.ready) begin
					o_valid_d   = 1'b1;
					o_status_d  = r_status_q;
					o_has_d     = r_has_q;
					o_id_d      = r_id_q;
					o_resched_d = r_resched_q;
					st_d        = edfbs_pkg::S_IDLE;
				end
			end
			default: st_d = edfbs_pkg::S_IDLE;
		endcase

		if (cfg_we) begin
			unique case (cfg_index)
				edfbs_pkg::REG_MS_PER_TICK:      mpt_d     = cfg_data[MW-1:0];
				edfbs_pkg::REG_START_MIN_PERIOD: least_d   = cfg_data[LW-1:0];
				edfbs_pkg::REG_START_MAX_BUDGET: largest_d = cfg_data[BW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= edfbs_pkg::S_IDLE;
			cnt_q       <= '0;
			addr_q      <= '0;
			pend_s1     <= 1'b0;
			found_q     <= 1'b0;
			now_q       <= '0;
			run_slot_q  <= '0;
			run_valid_q <= 1'b0;
			least_q     <= edfbs_pkg::SMIN_RST;
			largest_q   <= edfbs_pkg::SMAX_RST;
			hp_q        <= '0;
			mpt_q       <= edfbs_pkg::MPT_RST;
			o_valid_q   <= 1'b0;
		end else begin
			st_q        <= st_d;
			cnt_q       <= cnt_d;
			addr_q      <= addr_d;
			pend_s1     <= issue;
			found_q     <= found_d;
			now_q       <= now_d;
			run_slot_q  <= run_slot_d;
			run_valid_q <= run_valid_d;
			least_q     <= least_d;
			largest_q   <= largest_d;
			hp_q        <= hp_d;
			mpt_q       <= mpt_d;
			o_valid_q   <= o_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1      <= addr_q[AW-1:0];
		best_idx_q  <= best_idx_d;
		best_dl_q   <= best_dl_d;
		best_ws_q   <= best_ws_d;
		t_q         <= t_d;
		ga_q        <= ga_d;
		gb_q        <= gb_d;
		qt_q        <= qt_d;
		prod_q      <= prod_d;
		func_q      <= func_d;
		id_q        <= id_d;
		per_q       <= per_d;
		bud_q       <= bud_d;
		first_q     <= first_d;
		r_status_q  <= r_status_d;
		r_has_q     <= r_has_d;
		r_id_q      <= r_id_d;
		r_resched_q <= r_resched_d;
		o_status_q  <= o_status_d;
		o_has_q     <= o_has_d;
		o_id_q      <= o_id_d;
		o_resched_q <= o_resched_d;
	end

	assign req.ready      = (st_q == edfbs_pkg::S_IDLE);
	assign rsp.valid      = o_valid_q;
	assign rsp.status     = o_status_q;
	assign rsp.has_task   = o_has_q;
	assign rsp.chosen_id  = o_id_q;
	assign rsp.reschedule = o_resched_q;

	// the no-op code takes the short path straight to the result
	logic nop_item;
	assign nop_item = (func_q == edfbs_pkg::FN_NOP);

	`EDFBS_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CNT_FULL, "task count beyond table")
	`EDFBS_ASSERT_NOW(a_run_slot, run_valid_q, CW'(run_slot_q) < cnt_q, "running slot not admitted")
	`EDFBS_ASSERT_NEXT(a_one_item, req.valid && req.ready, !req.ready, "ready after accept")
	`EDFBS_ASSERT_NOW(a_nop_path, nop_item && (st_q == edfbs_pkg::S_DONE), !r_status_q && !r_has_q && !r_resched_q, "no-op gave a result")
endmodule

// ===== verif/edf_budget_scheduler_top_tb.sv =====
// self-checking testbench of the edf budget scheduler: directed table, then random phases
`timescale 1ns / 1ps
module edf_budget_scheduler_top_tb;
	import edfbs_pkg::*;

	localparam int SLOTS = 16;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [ID_W-1:0]   id;
		logic [PER_W-1:0]  period;
		logic [BUD_W-1:0]  budget;
		logic [FDL_W-1:0]  first;
	} sched_req_t;

	typedef struct packed {
		logic            status;
		logic            has_task;
		logic [ID_W-1:0] chosen_id;
		logic            reschedule;
	} sched_rsp_t;

	typedef struct packed {
		sched_req_t req;
		logic       known;
		sched_rsp_t rsp;
	} stim_row_t;

	localparam int N_ROWS = 21;
	localparam stim_row_t STIM_TABLE [N_ROWS] = '{
		'{'{FN_PICK, 8'h00, 12'd0, 8'd0, 16'h0000}, 1'b1, '{1'b0, 1'b0, 8'h00, 1'b0}},
		'{'{FN_TICK, 8'h00, 12'd0, 8'd0, 16'h0000}, 1'b1, '{1'b0, 1'b0, 8'h00, 1'b0}},
		'{'{FN_NOP, 8'hFF, 12'hFFF, 8'hFF, 16'hFFFF}, 1'b1, '{1'b0, 1'b0, 8'h00, 1'b0}},
		// period outside the set, widest budget makes the sticky maximum 255
		'{'{FN_ADD, 8'hFF, 12'hFFF, 8'hFF, 16'hFFFF}, 1'b1, '{1'b1, 1'b0, 8'h00, 1'b0}},
		// budget outside the set, period still folds into the hyperperiod
		'{'{FN_ADD, 8'h11, 12'd1000, 8'd3, 16'd5000}, 1'b1, '{1'b1, 1'b0, 8'h00, 1'b0}},
		'{'{FN_ADD, 8'hAA, 12'd1000, 8'd10, 16'd2000}, 1'b0, '0},
		'{'{FN_ADD, 8'h55, 12'd4000, 8'd200, 16'hFFFF}, 1'b0, '0},
		'{'{FN_ADD, 8'h00, 12'd100, 8'd1, 16'h0000}, 1'b0, '0},
		'{'{FN_ADD, 8'h01, 12'd500, 8'd20, 16'd300}, 1'b0, '0},
		'{'{FN_PICK, 8'h00, 12'd0, 8'd0, 16'h0000}, 1'b0, '0},
		'{'{FN_TICK, 8'h00, 12'd0, 8'd0, 16'h0000}, 1'b0, '0},
		'{'{FN_TICK, 8'h00, 12'd0, 8'd0, 16'h0000}, 1'b0, '0},
		'{'{FN_TICK, 8'h00, 12'd0, 8'd0, 16'h0000}, 1'b0, '0},
		'{'{FN_PICK, 8'h00, 12'd0, 8'd0, 16'h0000}, 1'b0, '0},
		'{'{FN_ADD, 8'h02, 12'd200, 8'd1, 16'd199}, 1'b0, '0},
		'{'{FN_PICK, 8'h00, 12'd0, 8'd0, 16'h0000}, 1'b0, '0},
		'{'{FN_TICK, 8'h00, 12'd0, 8'd0, 16'h0000}, 1'b0, '0},
		'{'{FN_TICK, 8'h00, 12'd0, 8'd0, 16'h0000}, 1'b0, '0},
		// zero period drops the sticky minimum below the maximum budget
		'{'{FN_ADD, 8'h00, 12'd0, 8'd0, 16'h0000}, 1'b1, '{1'b1, 1'b0, 8'h00, 1'b0}},
		'{'{FN_ADD, 8'h03, 12'd1000, 8'd1, 16'hFFFF}, 1'b1, '{1'b1, 1'b0, 8'h00, 1'b0}},
		'{'{FN_PICK, 8'h00, 12'd0, 8'd0, 16'h0000}, 1'b0, '0}
	};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	edfbs_in_if req();
	edfbs_out_if rsp();

	edf_budget_scheduler_top u_top (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// scheduler state as the block should hold it
	bit          slot_valid [SLOTS];
	bit [7:0]    slot_id [SLOTS];
	bit [11:0]   slot_period [SLOTS];
	bit [7:0]    slot_budget [SLOTS];
	bit [15:0]   slot_first [SLOTS];
	bit [31:0]   slot_deadline [SLOTS];
	bit [31:0]   slot_window [SLOTS];
	int          slot_slice [SLOTS];
	int          run_slot;
	bit          run_valid;
	bit [31:0]   now_ticks;
	int unsigned min_period, max_budget, hyper;
	int unsigned ms_tick;

	sched_rsp_t  expected_rsp [$];
	int          errors;
	int          pend_gap;
	bit          no_idle;
	int          n_admit, n_chosen, n_resched, n_items;

	initial begin
		clk = 1'b0;
		forever begin
			#5 clk = 1'b1;
			#5 clk = 1'b0;
		end
	end

	function automatic bit is_period(int unsigned v);
		for (int i = 0; i < PERIOD_CNT; i++)
			if (PERIOD_SET[i] == v) return 1'b1;
		return 1'b0;
	endfunction

	function automatic bit is_budget(int unsigned v);
		for (int i = 0; i < BUDGET_CNT; i++)
			if (BUDGET_SET[i] == v) return 1'b1;
		return 1'b0;
	endfunction

	function automatic int unsigned gcd_of(int unsigned a, int unsigned b);
		int unsigned r;
		while (b != 0) begin
			r = a % b;
			a = b;
			b = r;
		end
		return a;
	endfunction

	function bit table_full();
		for (int i = 0; i < SLOTS; i++)
			if (!slot_valid[i]) return 1'b0;
		return 1'b1;
	endfunction

	// edf run over one hyperperiod on scratch copies
	function bit edf_feasible();
		longint unsigned dl [SLOTS];
		longint unsigned ws [SLOTS];
		longint unsigned t;
		int k;
		t = 0;
		for (int i = 0; i < SLOTS; i++) begin
			dl[i] = slot_first[i];
			ws[i] = 0;
		end
		while (t < hyper) begin
			k = -1;
			for (int i = 0; i < SLOTS; i++)
				if (slot_valid[i] && (k < 0 || dl[i] < dl[k])) k = i;
			if (k < 0) return 1'b0;
			if (t + slot_budget[k] > dl[k]) return 1'b0;
			if (t < ws[k]) t = ws[k];
			t += (slot_budget[k] == 0) ? 1 : slot_budget[k];
			ws[k] += slot_period[k];
			dl[k] += slot_period[k];
		end
		return 1'b1;
	endfunction

	function bit admit_task(sched_req_t r);
		int slot;
		slot = -1;
		if (min_period > r.period) min_period = r.period;
		if (max_budget < r.budget) max_budget = r.budget;
		if (max_budget > min_period) return 1'b1;
		if (!is_period(r.period)) return 1'b1;
		if (hyper == 0 || hyper == r.period) hyper = r.period;
		else hyper = (hyper / gcd_of(hyper, r.period)) * r.period;
		hyper &= 32'h1FFFF;
		if (!is_budget(r.budget)) return 1'b1;
		for (int i = SLOTS - 1; i >= 0; i--)
			if (!slot_valid[i]) slot = i;
		if (slot < 0) return 1'b1;
		slot_valid[slot] = 1'b1;
		slot_id[slot] = r.id;
		slot_period[slot] = r.period;
		slot_budget[slot] = r.budget;
		slot_first[slot] = r.first;
		if (!edf_feasible()) begin
			slot_valid[slot] = 1'b0;
			return 1'b1;
		end
		for (int i = 0; i < SLOTS; i++)
			if (slot_valid[i]) begin
				slot_deadline[i] = slot_first[i];
				slot_window[i] = '0;
			end
		return 1'b0;
	endfunction

	function sched_rsp_t schedule_step(sched_req_t r);
		sched_rsp_t o;
		int k;
		o = '0;
		case (r.func)
			FN_ADD: begin
				o.status = admit_task(r);
				if (!o.status) n_admit++;
			end
			FN_TICK: begin
				now_ticks = now_ticks + 1;
				if (run_valid) begin
					k = run_slot;
					if (slot_slice[k] <= 0) begin
						if (slot_slice[k] > -256) slot_slice[k]--;
						slot_deadline[k] = slot_deadline[k] + slot_period[k];
						slot_window[k] = slot_window[k] + slot_period[k];
						o.reschedule = 1'b1;
						n_resched++;
					end else begin
						slot_slice[k]--;
					end
				end
			end
			FN_PICK: begin
				k = -1;
				for (int i = 0; i < SLOTS; i++)
					if (slot_valid[i] && (k < 0 || slot_deadline[i] < slot_deadline[k])) k = i;
				if (k >= 0 && longint'(slot_window[k]) <= longint'(ms_tick) * longint'(now_ticks))
						begin
					run_slot = k;
					run_valid = 1'b1;
					slot_slice[k] = slot_budget[k];
					o.has_task = 1'b1;
					o.chosen_id = slot_id[k];
					n_chosen++;
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	function int gap_len();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task report(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// drive one beat; prediction is taken at the accepting edge
	task send(sched_req_t r, bit known, sched_rsp_t kres);
		sched_rsp_t p;
		if (pend_gap > 0) repeat (pend_gap) @(posedge clk);
		req.valid <= 1'b1;
		req.func <= r.func;
		req.task_id <= r.id;
		req.task_period <= r.period;
		req.task_budget <= r.budget;
		req.first_deadline <= r.first;
		do @(posedge clk); while (!req.ready);
		p = schedule_step(r);
		expected_rsp.push_back(known ? kres : p);
		n_items++;
		pend_gap = gap_len();
		if (pend_gap > 0) req.valid <= 1'b0;
	endtask

	task drain();
		if (pend_gap == 0) begin
			req.valid <= 1'b0;
			pend_gap = 1;
		end
		while (expected_rsp.size() != 0) @(posedge clk);
	endtask

	task write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_DATA_W-1:0];
		@(posedge clk);
		case (idx)
			REG_MS_PER_TICK: ms_tick = value & 32'h3FF;
			REG_START_MIN_PERIOD: min_period = value & 32'h1FFF;
			REG_START_MAX_BUDGET: max_budget = value & 32'hFF;
			default: ;
		endcase
	endtask

	function sched_req_t rand_item(bit only_tick);
		sched_req_t r;
		int c;
		int unsigned cheap [6] = '{100, 200, 400, 500, 1000, 4000};
		r.id = $urandom;
		r.first = $urandom;
		r.period = $urandom;
		r.budget = $urandom;
		c = only_tick ? 50 : $urandom_range(0, 99);
		if (c < 30) begin
			r.func = FN_ADD;
			if (table_full()) begin
				// no simulation runs once full, so any period can fold in
				if ($urandom_range(0, 4) != 0) r.period = PERIOD_SET[$urandom_range(0, PERIOD_CNT - 1)];
			end else begin
				c = $urandom_range(0, 99);
				if (c < 80) r.period = cheap[$urandom_range(0, 5)];
				else if (c < 85) r.period = PERIOD_SET[$urandom_range(0, 3)];
				else if (is_period(r.period) && !(4000 % r.period == 0)) r.period = r.period + 1;
				if ($urandom_range(0, 1)) r.first = $urandom_range(30000, 65535);
			end
			if ($urandom_range(0, 99) < 85) r.budget = BUDGET_SET[$urandom_range(0, 5)];
		end else if (c < 80) begin
			r.func = FN_TICK;
		end else if (c < 96) begin
			r.func = FN_PICK;
		end else begin
			r.func = FN_NOP;
		end
		return r;
	endfunction

	initial begin
		sched_req_t r;
		int unsigned mpt_v, min_v, max_v;
		errors = 0;
		n_admit = 0;
		n_chosen = 0;
		n_resched = 0;
		n_items = 0;
		pend_gap = 1;
		no_idle = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req.valid = 1'b0;
		req.func = FN_NOP;
		req.task_id = '0;
		req.task_period = '0;
		req.task_budget = '0;
		req.first_deadline = '0;
		for (int i = 0; i < SLOTS; i++) begin
			slot_valid[i] = 1'b0;
			slot_slice[i] = 0;
		end
		run_slot = 0;
		run_valid = 1'b0;
		now_ticks = '0;
		ms_tick = MPT_RST;
		min_period = SMIN_RST;
		max_budget = SMAX_RST;
		hyper = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_ROWS; i++)
			send(STIM_TABLE[i].req, STIM_TABLE[i].known, STIM_TABLE[i].rsp);

		for (int ph = 0; ph < 8; ph++) begin
			drain();
			case (ph)
				0: begin mpt_v = 10; min_v = 5000; max_v = 200; end
				1: begin mpt_v = 1; min_v = 5000; max_v = 0; end
				2: begin mpt_v = 1000; min_v = 4000; max_v = 200; end
				3: begin mpt_v = 500; min_v = 1; max_v = 200; end
				4: begin mpt_v = 1; min_v = 1; max_v = 0; end
				default: begin
					mpt_v = $urandom_range(1, 1000);
					min_v = $urandom_range(200, 5000);
					max_v = $urandom_range(0, 200);
				end
			endcase
			write_reg(REG_MS_PER_TICK, mpt_v);
			write_reg(REG_START_MIN_PERIOD, min_v);
			write_reg(REG_START_MAX_BUDGET, max_v);
			cfg_we <= 1'b0;
			no_idle = (ph == 5);
			for (int n = 0; n < 55; n++) begin
				if (ph == 1 && n == 20) drain();
				// long tick run drives the slice counter into saturation
				if (ph == 2 && n == 10)
					for (int b = 0; b < 300; b++) send(rand_item(1'b1), 1'b0, '0);
				send(rand_item(1'b0), 1'b0, '0);
			end
		end

		drain();
		repeat (100) @(posedge clk);
		$display("covered %0d beats: %0d tasks admitted, %0d picks chose a task, %0d reschedules",
			n_items, n_admit, n_chosen, n_resched);
		if (errors == 0)
			$display("edf_budget_scheduler_top_tb OK");
		else
			$display("edf_budget_scheduler_top_tb NOT OK");
		$finish;
	end

	// response side back-pressure
	initial begin
		int g;
		rsp.ready = 1'b0;
		@(posedge clk);
		forever begin
			rsp.ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			g = gap_len();
			if (g > 0) begin
				rsp.ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		sched_rsp_t e;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_rsp.size() == 0) begin
				$display("unexpected result beat at %0t", $realtime);
				errors++;
			end else begin
				e = expected_rsp.pop_front();
				if (rsp.status !== e.status) report("status", rsp.status, e.status);
				if (rsp.has_task !== e.has_task) report("has_task", rsp.has_task, e.has_task);
				if (rsp.chosen_id !== e.chosen_id) report("chosen_id", rsp.chosen_id, e.chosen_id);
				if (rsp.reschedule !== e.reschedule)
					report("reschedule", rsp.reschedule, e.reschedule);
			end
		end
	end

	initial begin
		#400_000_000;
		$display("timeout with %0d results outstanding", expected_rsp.size());
		$display("edf_budget_scheduler_top_tb NOT OK");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/edfbs_pkg.sv
rtl/edfbs_if.sv
rtl/edfbs_ram.sv
rtl/edfbs_div.sv
rtl/edf_budget_scheduler_top.sv
verif/edf_budget_scheduler_top_tb.sv
